// ===== src/tbs_pkg.sv =====
// Shared types and constants for the token bucket shaper.
// Used by every module of the block except the generic RAM.
package tbs_pkg;

  localparam int TBS_QUEUE_DEPTH = 64;
  localparam int TBS_ID_WIDTH    = 16;
  localparam int TBS_TOK_WIDTH   = 8;
  localparam int TBS_QCNT_WIDTH  = 7;
  localparam int TBS_EV_WIDTH    = 3;

  localparam logic [TBS_TOK_WIDTH-1:0] TBS_DEPTH_RESET = 8'd10;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ARRIVAL = 1'b1;

  typedef enum logic [TBS_EV_WIDTH-1:0] {
    EV_TOKEN_KEPT    = 3'd0,
    EV_TOKEN_DROPPED = 3'd1,
    EV_TOO_BIG       = 3'd2,
    EV_QUEUED        = 3'd3,
    EV_RELEASED      = 3'd4,
    EV_QUEUE_FULL    = 3'd5
  } tbs_event_t;

  typedef struct packed {
    logic                     command;
    logic [TBS_ID_WIDTH-1:0]  packet_id;
    logic [TBS_TOK_WIDTH-1:0] tokens_needed;
  } tbs_in_t;

  typedef struct packed {
    tbs_event_t                event_res;
    logic                      release_valid;
    logic [TBS_ID_WIDTH-1:0]   release_id;
    logic [TBS_TOK_WIDTH-1:0]  bucket_level;
    logic [TBS_QCNT_WIDTH-1:0] queue_count;
  } tbs_out_t;

  // One waiting packet.
  typedef struct packed {
    logic [TBS_ID_WIDTH-1:0]  id;
    logic [TBS_TOK_WIDTH-1:0] need;
  } tbs_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } tbs_fifo_cmd_t;

endpackage

// ===== src/token_bucket_shaper.sv =====
// Token bucket shaper. Each input transfer is a token tick or a packet
// arrival and yields exactly one result transfer. Items pass an input
// register, combinational decision logic against the bucket level and the
// queue head, and a result register, so one item is taken per clock when
// the result side keeps up. The waiting queue holds QUEUE_DEPTH packets
// in a RAM with a head register refilled by a registered read after every
// release from the queue. The bucket depth register at byte address 0
// resets to 10; the user must write it only while the block is idle; the
// block does not enforce this. Depends on tbs_pkg, tbs_cfg, tbs_fifo and tbs_ram.
module token_bucket_shaper
  import tbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = TBS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tbs_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tbs_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  logic                     in_valid_r;
  tbs_in_t                  in_r;
  logic                     out_valid_r;
  tbs_out_t                 out_r, out_nxt;
  logic [TBS_TOK_WIDTH-1:0] level_r, level_nxt;
  logic [TBS_TOK_WIDTH-1:0] bucket_depth;
  logic [TBS_TOK_WIDTH-1:0] lvl_tick;
  logic                     proc_fire;
  tbs_fifo_cmd_t            fifo_cmd, fifo_req;
  tbs_entry_t               head;
  tbs_entry_t               push_entry;
  logic [CNT_W-1:0]         count, count_after;
  logic [CNT_W+6:0]         count_ext;

  tbs_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .bucket_depth (bucket_depth)
  );

  tbs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (fifo_cmd),
    .push_entry (push_entry),
    .head       (head),
    .count      (count)
  );

  assign proc_fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || proc_fire;

  assign push_entry.id   = in_r.packet_id;
  assign push_entry.need = in_r.tokens_needed;

  always_comb begin
    fifo_req      = '0;
    level_nxt     = level_r;
    lvl_tick      = level_r;
    out_nxt       = '0;
    out_nxt.event_res = EV_TOKEN_KEPT;
    if (in_r.command == CMD_TICK) begin
      // The new token is dropped when the bucket is already at (or above) depth.
      if (level_r >= bucket_depth) begin
        out_nxt.event_res = EV_TOKEN_DROPPED;
      end else begin
        lvl_tick = level_r + 1'b1;
      end
      level_nxt = lvl_tick;
      if ((count != '0) && (head.need <= lvl_tick)) begin
        fifo_req.pop          = 1'b1;
        level_nxt             = lvl_tick - head.need;
        out_nxt.release_valid = 1'b1;
        out_nxt.release_id    = head.id;
      end
    end else begin
      if (in_r.tokens_needed > bucket_depth) begin
        out_nxt.event_res = EV_TOO_BIG;
      end else if ((count == '0) && (in_r.tokens_needed <= level_r)) begin
        level_nxt             = level_r - in_r.tokens_needed;
        out_nxt.event_res     = EV_RELEASED;
        out_nxt.release_valid = 1'b1;
        out_nxt.release_id    = in_r.packet_id;
      end else if (count == CNT_W'(QUEUE_DEPTH)) begin
        out_nxt.event_res = EV_QUEUE_FULL;
      end else begin
        fifo_req.push     = 1'b1;
        out_nxt.event_res = EV_QUEUED;
      end
    end
    out_nxt.bucket_level = level_nxt;
    out_nxt.queue_count  = count_ext[TBS_QCNT_WIDTH-1:0];
  end

  always_comb begin
    if (fifo_req.push) begin
      count_after = count + 1'b1;
    end else if (fifo_req.pop) begin
      count_after = count - 1'b1;
    end else begin
      count_after = count;
    end
  end

  assign count_ext = {7'b0, count_after};

  assign fifo_cmd.push = fifo_req.push && proc_fire;
  assign fifo_cmd.pop  = fifo_req.pop && proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (proc_fire) begin
        in_valid_r <= 1'b0;
      end
      if (proc_fire) begin
        out_valid_r <= 1'b1;
        level_r     <= level_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (proc_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/tbs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/tbs_cfg.sv =====
// APB-style configuration register file holding the bucket depth.
// Depends on tbs_pkg.
module tbs_cfg
  import tbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic [TBS_TOK_WIDTH-1:0] bucket_depth
);

  logic [TBS_TOK_WIDTH-1:0] depth_r;
  logic                     wr_hit;

  // Byte offsets within a word are ignored; word 0 is the only register.
  assign wr_hit = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= TBS_DEPTH_RESET;
    end else if (wr_hit) begin
      depth_r <= pwdata[TBS_TOK_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'b0) begin
      prdata = {{(32-TBS_TOK_WIDTH){1'b0}}, depth_r};
    end
  end

  assign pready       = 1'b1;
  assign bucket_depth = depth_r;

endmodule

// ===== src/tbs_fifo.sv =====
// Waiting queue of packets: RAM storage plus a head register so the head
// entry is always visible combinationally. Depends on tbs_pkg and tbs_ram.
module tbs_fifo
  import tbs_pkg::*;
#(
  parameter int DEPTH = TBS_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tbs_fifo_cmd_t              cmd,
  input  tbs_entry_t                 push_entry,
  output tbs_entry_t                 head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int ENT_W = $bits(tbs_entry_t);

  logic [PTR_W-1:0] head_ptr_r, head_ptr_nxt;
  logic [PTR_W-1:0] tail_ptr_r, tail_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic             fetch_r;
  tbs_entry_t       head_r;
  tbs_entry_t       head_cur;
  logic [ENT_W-1:0] rd_data;

  assign head_ptr_nxt = (head_ptr_r == PTR_W'(DEPTH-1)) ? '0 : head_ptr_r + 1'b1;
  assign tail_ptr_nxt = (tail_ptr_r == PTR_W'(DEPTH-1)) ? '0 : tail_ptr_r + 1'b1;

  // After a pop the new head is read from RAM; it shows up on the read
  // register in the next cycle and is used straight from there.
  assign head_cur = fetch_r ? tbs_entry_t'(rd_data) : head_r;

  tbs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail_ptr_r),
    .wr_data (push_entry),
    .rd_en   (cmd.pop),
    .rd_addr (head_ptr_nxt),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_ptr_r <= '0;
      tail_ptr_r <= '0;
      count_r    <= '0;
      fetch_r    <= 1'b0;
    end else begin
      if (cmd.push) begin
        tail_ptr_r <= tail_ptr_nxt;
        count_r    <= count_r + 1'b1;
      end else if (cmd.pop) begin
        head_ptr_r <= head_ptr_nxt;
        count_r    <= count_r - 1'b1;
      end
      fetch_r <= cmd.pop && (count_r != CNT_W'(1));
    end
  end

  // A push into an empty queue becomes the head directly.
  always_ff @(posedge clk) begin
    if (cmd.push && (count_r == '0)) begin
      head_r <= push_entry;
    end else begin
      head_r <= head_cur;
    end
  end

  assign head  = head_cur;
  assign count = count_r;

endmodule
